[src/length_checked_frame_deframer_defines.svh]
`ifndef LENGTH_CHECKED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_CHECKED_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle check, clocked on clk_i, off during reset
`define LCFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define LCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lcfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lcfd_pkg;

  localparam int unsigned BufferDepth = 64;
  localparam int unsigned AddrW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
  localparam int unsigned CntW = $clog2(BufferDepth + 1);

  localparam logic [7:0] StartByte = 8'hFE;
  localparam logic [7:0] MarkByte = 8'h3F;
  localparam logic [7:0] EndByte = 8'hFF;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhLen = 2'd1;
  localparam logic [1:0] PhData = 2'd2;

endpackage

`default_nettype wire

[src/length_checked_frame_deframer.sv]
// Length-checked frame deframer. Each input transaction carries one received
// serial byte; a start byte (0xFE or 0x3F) opens a frame, the next byte is the
// expected payload length, and payload bytes are buffered (64 deep) until an
// end byte (0xFF or 0x3F). If the buffered count equals the length, the
// payload is replayed as one output transaction per byte with last_byte_o on
// the final one; otherwise the frame is dropped silently, and a byte that
// arrives with the buffer full abandons the frame. While receiving, one byte
// is taken every cycle. Replay goes through the single buffer read port and
// the output register: each payload byte is read in StRd, then presented in
// StOut and held through any output stall, and no input is taken until the
// final byte has been accepted. The buffer needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "length_checked_frame_deframer_defines.svh"

module length_checked_frame_deframer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] byte_in_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic [7:0]      payload_byte_o,
  output logic            last_byte_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i
);

  localparam logic [1:0] StRx = 2'd0;
  localparam logic [1:0] StRd = 2'd1;
  localparam logic [1:0] StOut = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic [7:0] exp_len_q, exp_len_d;
  logic [lcfd_pkg::CntW-1:0] count_q, count_d;
  logic [lcfd_pkg::AddrW-1:0] rd_idx_q, rd_idx_d;
  logic [7:0] rd_data_q;
  logic wr_en;
  logic is_end;
  logic is_start;
  logic len_match;
  logic rd_last;

  logic [7:0] mem [lcfd_pkg::BufferDepth];

  assign is_end = (byte_in_i == lcfd_pkg::EndByte) || (byte_in_i == lcfd_pkg::MarkByte);
  assign is_start = (byte_in_i == lcfd_pkg::StartByte) || (byte_in_i == lcfd_pkg::MarkByte);
  assign len_match = ({{(8 - lcfd_pkg::CntW){1'b0}}, count_q} == exp_len_q);
  assign rd_last = (({1'b0, rd_idx_q} + lcfd_pkg::CntW'(1)) == count_q);

  assign in_stall_o = (state_q != StRx);
  assign out_valid_o = (state_q == StOut);
  assign payload_byte_o = rd_data_q;
  assign last_byte_o = rd_last;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    exp_len_d = exp_len_q;
    count_d = count_q;
    rd_idx_d = rd_idx_q;
    wr_en = 1'b0;
    unique case (state_q)
      StRx: begin
        if (in_valid_i) begin
          unique case (phase_q)
            lcfd_pkg::PhLen: begin
              exp_len_d = byte_in_i;
              phase_d = lcfd_pkg::PhData;
            end
            lcfd_pkg::PhData: begin
              if (is_end) begin
                phase_d = lcfd_pkg::PhIdle;
                if (len_match && (count_q != '0)) begin
                  state_d = StRd;
                  rd_idx_d = '0;
                end else begin
                  count_d = '0;
                  if (!len_match) begin
                    exp_len_d = '0;
                  end
                end
              end else if (count_q >= lcfd_pkg::CntW'(lcfd_pkg::BufferDepth)) begin
                count_d = '0;
                phase_d = lcfd_pkg::PhIdle;
              end else begin
                wr_en = 1'b1;
                count_d = count_q + lcfd_pkg::CntW'(1);
              end
            end
            default: begin
              phase_d = is_start ? lcfd_pkg::PhLen : lcfd_pkg::PhIdle;
            end
          endcase
        end
      end
      StRd: begin
        state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) begin
          if (rd_last) begin
            state_d = StRx;
            count_d = '0;
          end else begin
            rd_idx_d = rd_idx_q + lcfd_pkg::AddrW'(1);
            state_d = StRd;
          end
        end
      end
      default: begin
        state_d = StRx;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRx;
      phase_q <= lcfd_pkg::PhIdle;
      exp_len_q <= '0;
      count_q <= '0;
      rd_idx_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      exp_len_q <= exp_len_d;
      count_q <= count_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  // single-port payload buffer, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[lcfd_pkg::AddrW-1:0]] <= byte_in_i;
    end
    if (state_q == StRd) begin
      rd_data_q <= mem[rd_idx_q];
    end
  end

  `LCFD_ASSERT(a_out_blocks_in, !out_valid_o || in_stall_o, "output pending while input open")
  `LCFD_ASSERT(a_count_bound, count_q <= lcfd_pkg::CntW'(lcfd_pkg::BufferDepth),
               "stored count beyond buffer depth")
  `LCFD_ASSERT_NEXT(a_read_then_show, state_q == StRd, out_valid_o, "read not followed by output")
  `LCFD_ASSERT_NEXT(a_last_frees_in, out_valid_o && !out_stall_i && last_byte_o, !in_stall_o,
                    "input not reopened after last byte")

endmodule

`default_nettype wire
